// ===== rtl/jabl_pkg.sv =====
// jabl_pkg: shared types and constants of the action block locator
// no dependencies; imported by jabl_scan and the top level
`default_nettype none

package jabl_pkg;

    // width of the offset and count fields of a result
    localparam int unsigned OFFSET_W = 20;
    localparam int unsigned COUNT_W  = 16;

    // scanner phases
    localparam logic [1:0] PH_KEY     = 2'd0;
    localparam logic [1:0] PH_BRACKET = 2'd1;
    localparam logic [1:0] PH_BRACE   = 2'd2;
    localparam logic [1:0] PH_OBJECT  = 2'd3;

    // characters the scanner reacts to
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_LBRACK = 16'h005B;
    localparam logic [15:0] CH_LBRACE = 16'h007B;
    localparam logic [15:0] CH_RBRACE = 16'h007D;

    // length of the quoted key, quotes included
    localparam logic [3:0] KEY_LEN = 4'd9;

    // one result transaction
    typedef struct packed {
        logic                emit;
        logic                found;
        logic [OFFSET_W-1:0] start;
        logic [OFFSET_W-1:0] stop;
        logic [COUNT_W-1:0]  count;
        logic                done;
        logic                error;
    } t_result;

    // characters of the quoted key "actions"
    function automatic logic [15:0] key_char(input logic [3:0] idx);
        logic [15:0] ch;
        case (idx)
            4'd0:    ch = CH_QUOTE;
            4'd1:    ch = 16'h0061;
            4'd2:    ch = 16'h0063;
            4'd3:    ch = 16'h0074;
            4'd4:    ch = 16'h0069;
            4'd5:    ch = 16'h006F;
            4'd6:    ch = 16'h006E;
            4'd7:    ch = 16'h0073;
            4'd8:    ch = CH_QUOTE;
            default: ch = 16'h0000;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jabl_in_buf.sv =====
// jabl_in_buf: input register with a skid entry, so the stall toward
// the sender is a register output; uses no package items
`default_nettype none

module jabl_in_buf (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_char_code,
    input  wire logic        i_last_char,
    input  wire logic        i_take,
    output logic             o_valid,
    output logic [15:0]      o_char_code,
    output logic             o_last_char
);

    logic        r_valid, n_valid;
    logic [15:0] r_char, n_char;
    logic        r_last, n_last;
    logic        r_sk_valid, n_sk_valid;
    logic [15:0] r_sk_char, n_sk_char;
    logic        r_sk_last, n_sk_last;
    logic        w_move;
    logic        w_acc;

    // main entry moves when empty or consumed; skid fills only when main holds
    assign w_move = !r_valid || i_take;
    assign w_acc  = i_valid && !r_sk_valid;

    always_comb begin
        n_valid    = r_valid;
        n_char     = r_char;
        n_last     = r_last;
        n_sk_valid = r_sk_valid;
        n_sk_char  = r_sk_char;
        n_sk_last  = r_sk_last;
        if (w_move) begin
            if (r_sk_valid) begin
                n_valid    = 1'b1;
                n_char     = r_sk_char;
                n_last     = r_sk_last;
                n_sk_valid = 1'b0;
            end else begin
                n_valid = w_acc;
                n_char  = i_char_code;
                n_last  = i_last_char;
            end
        end else if (w_acc) begin
            n_sk_valid = 1'b1;
            n_sk_char  = i_char_code;
            n_sk_last  = i_last_char;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_sk_valid <= n_sk_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_last    <= n_last;
        r_sk_char <= n_sk_char;
        r_sk_last <= n_sk_last;
    end

    assign o_stall     = r_sk_valid;
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

// ===== rtl/jabl_scan.sv =====
// jabl_scan: scanner state and the per-character update logic
// depends on jabl_pkg for phases, characters and the result type
`default_nettype none

module jabl_scan #(
    parameter int unsigned POSITION_BITS = 20,
    parameter int unsigned DEPTH_BITS    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [15:0]      i_char_code,
    input  wire logic             i_last_char,
    output jabl_pkg::t_result     o_res
);

    import jabl_pkg::*;

    logic [1:0]               r_phase, n_phase;
    logic [3:0]               r_key, n_key;
    logic [DEPTH_BITS-1:0]    r_depth, n_depth;
    logic                     r_in_str, n_in_str;
    logic                     r_esc, n_esc;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_open, n_open;
    logic [COUNT_W-1:0]       r_count, n_count;
    logic                     r_halt, n_halt;
    logic                     w_found;
    logic                     w_err;
    logic [DEPTH_BITS-1:0]    w_depth_dn;
    logic [POSITION_BITS+OFFSET_W-1:0] w_open_ext;
    logic [POSITION_BITS+OFFSET_W-1:0] w_pos_ext;

    assign w_open_ext = {{OFFSET_W{1'b0}}, r_open};
    assign w_pos_ext  = {{OFFSET_W{1'b0}}, r_pos};
    assign w_depth_dn = (r_depth != '0) ? r_depth - 1'b1 : r_depth;

    // next state for one character
    always_comb begin
        n_phase  = r_phase;
        n_key    = r_key;
        n_depth  = r_depth;
        n_in_str = r_in_str;
        n_esc    = r_esc;
        n_pos    = r_pos;
        n_open   = r_open;
        n_count  = r_count;
        n_halt   = r_halt;
        w_found  = 1'b0;
        w_err    = 1'b0;
        if (!r_halt) begin
            if (&r_pos) begin
                // position capacity used up
                n_halt = 1'b1;
                w_err  = 1'b1;
            end else begin
                case (r_phase)
                    PH_KEY: begin
                        if (i_char_code == key_char(r_key)) begin
                            if (r_key == KEY_LEN - 4'd1) begin
                                n_phase = PH_BRACKET;
                                n_key   = 4'd0;
                            end else begin
                                n_key = r_key + 4'd1;
                            end
                        end else begin
                            n_key = (i_char_code == CH_QUOTE) ? 4'd1 : 4'd0;
                        end
                    end
                    PH_BRACKET: begin
                        if (i_char_code == CH_LBRACK) begin
                            n_phase = PH_BRACE;
                        end
                    end
                    PH_BRACE: begin
                        if (i_char_code == CH_LBRACE) begin
                            n_open   = r_pos;
                            n_depth  = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
                            n_in_str = 1'b0;
                            n_esc    = 1'b0;
                            n_phase  = PH_OBJECT;
                        end
                    end
                    PH_OBJECT: begin
                        if (r_in_str) begin
                            if (r_esc) begin
                                n_esc = 1'b0;
                            end else if (i_char_code == CH_BSLASH) begin
                                n_esc = 1'b1;
                            end else if (i_char_code == CH_QUOTE) begin
                                n_in_str = 1'b0;
                            end
                        end else if (i_char_code == CH_QUOTE) begin
                            n_in_str = 1'b1;
                        end else if (i_char_code == CH_LBRACE) begin
                            if (&r_depth) begin
                                n_halt = 1'b1;
                                w_err  = 1'b1;
                            end else begin
                                n_depth = r_depth + 1'b1;
                            end
                        end else if (i_char_code == CH_RBRACE) begin
                            n_depth = w_depth_dn;
                            if (w_depth_dn == '0) begin
                                w_found = 1'b1;
                                n_phase = PH_BRACE;
                                if (r_count != {COUNT_W{1'b1}}) begin
                                    n_count = r_count + 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
                if (!n_halt) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    // result for this character
    always_comb begin
        o_res.emit  = w_found || w_err || i_last_char;
        o_res.found = w_found;
        o_res.start = w_found ? w_open_ext[OFFSET_W-1:0] : '0;
        o_res.stop  = w_found ? w_pos_ext[OFFSET_W-1:0] : '0;
        o_res.count = n_count;
        o_res.done  = i_last_char;
        o_res.error = n_halt;
    end

    // state update; the last character returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_char)) begin
            r_phase  <= PH_KEY;
            r_key    <= 4'd0;
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
            r_pos    <= '0;
            r_open   <= '0;
            r_count  <= '0;
            r_halt   <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_key    <= n_key;
            r_depth  <= n_depth;
            r_in_str <= n_in_str;
            r_esc    <= n_esc;
            r_pos    <= n_pos;
            r_open   <= n_open;
            r_count  <= n_count;
            r_halt   <= n_halt;
        end
    end

    // a document end clears the scanner
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_last_char |=> r_phase == PH_KEY && r_count == '0 && !r_halt)
        else $error("scanner not cleared after last character");

    // an open object always has nonzero depth
    a_obj_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_OBJECT |-> r_depth != '0)
        else $error("object phase with zero depth");

    // key progress stays below the key length
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key < KEY_LEN)
        else $error("key match index out of range");

    // a halted scanner does not advance its position
    a_halt_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt && i_take && !i_last_char |=> $stable(r_pos) && r_halt)
        else $error("halted scanner moved");

endmodule

`default_nettype wire

// ===== rtl/json_action_block_locator_top.sv =====
// json_action_block_locator_top: top level of the action block locator
// depends on jabl_pkg, jabl_in_buf and jabl_scan
`default_nettype none

// Takes one UTF-16 character per cycle and sustains one character per
// cycle as long as the result side does not stall. That rate is set by
// the scanner state update, a loop on the phase, depth, string and
// position registers. A character is accepted into the input register,
// or into its skid entry while that register holds, and is scanned while
// it sits in the input register and the result register can take its
// result. Its result, if any, is valid at the output from the next edge
// on. A result transaction is given when an object closes, on a depth
// or position overflow, and on the character marked last, which also
// clears the scanner for the next document. While a result waits under
// output stall, the next character is held in the input register.
// Input stall comes straight from a register.
module json_action_block_locator_top #(
    parameter int unsigned POSITION_BITS = 20,
    parameter int unsigned DEPTH_BITS    = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_char_code,
    input  wire logic        i_last_char,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_block_found,
    output logic [19:0]      o_block_start,
    output logic [19:0]      o_block_end,
    output logic [15:0]      o_blocks_so_far,
    output logic             o_doc_done,
    output logic             o_scan_error
);

    import jabl_pkg::*;

    logic        w_in_valid;
    logic [15:0] w_char;
    logic        w_last;
    logic        w_out_ready;
    logic        w_take;
    t_result     w_res;
    logic        r_o_valid;
    t_result     r_res;

    // input register with skid
    jabl_in_buf u_in_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_take      (w_take),
        .o_valid     (w_in_valid),
        .o_char_code (w_char),
        .o_last_char (w_last)
    );

    // a character is scanned when the result register can take its result
    assign w_out_ready = !r_o_valid || !i_stall;
    assign w_take      = w_in_valid && w_out_ready;

    jabl_scan #(
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_char_code (w_char),
        .i_last_char (w_last),
        .o_res       (w_res)
    );

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_take && w_res.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_take && w_res.emit) begin
            r_res <= w_res;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_block_found   = r_res.found;
    assign o_block_start   = r_res.start;
    assign o_block_end     = r_res.stop;
    assign o_blocks_so_far = r_res.count;
    assign o_doc_done      = r_res.done;
    assign o_scan_error    = r_res.error;

endmodule

`default_nettype wire
